### design/bmsi_pkg.sv
// Package for the burn map similarity block: widths, codes, FSM states and
// divider request/response types. No dependencies.
`default_nettype none

package bmsi_pkg;

  localparam int CNT_W     = 21;              // pixel counts (saturating) and veg counts
  localparam int FRAC_W    = 16;              // Q1.16 fraction bits
  localparam int Q_W       = FRAC_W + 1;      // Q1.16 result width
  localparam int MAX_VEG   = 16;
  localparam int VEG_IDX_W = 4;
  localparam int VEG_N_W   = 5;               // holds 1..MAX_VEG
  localparam int UNI_W     = CNT_W + 1;
  localparam int TOT_W     = CNT_W + VEG_IDX_W;
  localparam int DSUM_W    = Q_W + VEG_IDX_W;
  localparam int LS_W      = 16;
  localparam int DIV_N_W   = 40;              // dividend / quotient bits
  localparam int DIV_D_W   = TOT_W;           // divisor bits
  localparam int DIV_CNT_W = 6;
  localparam int Q32_W     = 33;              // Q32 values up to 1.0

  localparam logic [Q_W-1:0]     ONE_Q     = Q_W'(1) << FRAC_W;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [31:0]        EINV_Q32  = 32'd1580030169;
  localparam logic [Q32_W-1:0]   Q32_ONE   = Q32_W'(1) << 32;
  localparam logic [LS_W-1:0]    LS_RESET  = 16'd13107;
  localparam logic [VEG_N_W-1:0] VT_RESET  = 5'd16;
  localparam logic [3:0]         TAYLOR_N  = 4'd12;

  typedef enum logic [0:0] {
    CFG_LENGTH_SCALE = 1'b0,
    CFG_VEG_TYPES    = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_COUNT = 1'b1
  } req_e;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SP,
    ST_SP_WAIT,
    ST_A_RD,
    ST_A_ACC,
    ST_A_WAIT,
    ST_B_CHK,
    ST_B_RD,
    ST_B_LAT,
    ST_B_DIVA,
    ST_B_DIVB,
    ST_DU,
    ST_DU_WAIT,
    ST_SQ,
    ST_X,
    ST_X_WAIT,
    ST_TAY_MUL,
    ST_TAY_DIV,
    ST_TAY_WAIT,
    ST_CLAMP,
    ST_KLOOP,
    ST_ROUND,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/burn_map_similarity_indices.sv
// Top level of the burn map similarity block: counters, veg count memory,
// compute sequencer. Depends on bmsi_pkg and bmsi_div.
`default_nettype none

// Compares two burn maps. Pixel-pair requests (tuser = 0) and veg count-pair
// requests (tuser = 1) are accepted one per cycle, back to back, while the
// block is loading. A request with tlast set starts the final compute, during
// which s_axis_tready is low. The compute is run by one sequencer around a
// shared restoring divider (40 quotient bits) and a 16-entry veg count memory
// with a registered read: one spatial division (none for an empty union), a
// walk of n = veg_types_used entries with one division per non-empty type, a
// second walk with two divisions per type (only when both veg totals are
// nonzero), the mean, the Gaussian argument, twelve Taylor divisions and up
// to about two dozen e^-1 multiplies. The result stays in the output register
// until taken; loading of the next run goes on meanwhile, and a new compute
// hands over its result only once the old one is gone. The veg store reads
// zero after reset and after each result (per-entry valid bits, cleared at
// once); the pixel counters only clear on reset. Configuration writes are
// taken at any time.
module burn_map_similarity_indices import bmsi_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // config write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_addr_i,
  input  wire logic [15:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // burned_a[0], burned_b[1], veg_index[5:2], count_a[26:6], count_b[47:27]
  input  wire logic [47:0]  s_axis_tdata,
  // req_type[0]
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // spatial_overlap[16:0], veg_dist_overlap[33:17], norm_similarity[50:34],
  // gauss_similarity[67:51], quad_similarity[84:68], mix_sp_norm_half[101:85],
  // mix_sp_norm_three_q[118:102], mix_sp_gauss_half[135:119],
  // mix_sp_gauss_three_q[152:136], mix_sp_quad_half[169:153],
  // mix_sp_quad_three_q[186:170], zero [191:187]
  output logic [191:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);

  // ---------------- config ----------------
  logic [LS_W-1:0]    ls_q;
  logic [VEG_N_W-1:0] vt_q;
  logic [VEG_N_W-1:0] n_eff;
  logic [VEG_IDX_W-1:0] idx_last;
  logic [LS_W-1:0]    ls_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q <= LS_RESET;
      vt_q <= VT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_LENGTH_SCALE: ls_q <= cfg_data_i;
        CFG_VEG_TYPES:    vt_q <= cfg_data_i[VEG_N_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp n to 1..MAX_VEG, scale zero acts as one
  assign n_eff    = (vt_q == '0) ? VEG_N_W'(1) :
                    (vt_q > VEG_N_W'(MAX_VEG)) ? VEG_N_W'(MAX_VEG) : vt_q;
  assign idx_last = VEG_IDX_W'(n_eff - 1'b1);
  assign ls_eff   = (ls_q == '0) ? LS_W'(1) : ls_q;

  // ---------------- input fields ----------------
  logic                 in_acc;
  logic                 in_a, in_b;
  logic [VEG_IDX_W-1:0] in_idx;
  logic [CNT_W-1:0]     in_ca, in_cb;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_a   = s_axis_tdata[0];
  assign in_b   = s_axis_tdata[1];
  assign in_idx = s_axis_tdata[5:2];
  assign in_ca  = s_axis_tdata[26:6];
  assign in_cb  = s_axis_tdata[47:27];

  // ---------------- FSM ----------------
  state_e state_q, state_d;
  logic   m_valid_q;
  div_req_t div_req;
  div_rsp_t div_rsp;

  bmsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // pixel counters
  logic [CNT_W-1:0] common_q, sf_q, sb_q;
  logic [UNI_W-1:0] uni;
  assign uni = UNI_W'(sf_q) + UNI_W'(sb_q) - UNI_W'(common_q);

  // veg memory: {count_b, count_a}, valid bits give the cleared value
  logic [2*CNT_W-1:0]   mem [MAX_VEG];
  logic [MAX_VEG-1:0]   vld_q;
  logic [VEG_IDX_W-1:0] rd_addr;
  logic [2*CNT_W-1:0]   rd_q;
  logic                 rd_vld_q;
  logic [CNT_W-1:0]     rd_a, rd_b;
  logic [CNT_W:0]       rd_s;
  logic [CNT_W-1:0]     rd_d;

  assign rd_a = rd_vld_q ? rd_q[CNT_W-1:0] : '0;
  assign rd_b = rd_vld_q ? rd_q[2*CNT_W-1:CNT_W] : '0;
  assign rd_s = {1'b0, rd_a} + {1'b0, rd_b};
  assign rd_d = (rd_a > rd_b) ? rd_a - rd_b : rd_b - rd_a;

  // compute registers
  logic [VEG_IDX_W-1:0] idx_q;
  logic [1:0]           status_q;
  logic [Q_W-1:0]       sp_q, vd_q, du_q, sq_q, gs_q, pa_q;
  logic [TOT_W-1:0]     ta_q, tb_q;
  logic [DSUM_W-1:0]    dsum_q, vsum_q;
  logic [CNT_W-1:0]     b_q;
  logic [Q_W-1:0]       k_q;
  logic [31:0]          fi_q;
  logic [Q32_W-1:0]     term_q, prod_q, r_q;
  logic signed [Q32_W+1:0] sum_q;
  logic [3:0]           nstep_q;
  logic                 idx_end, out_free, k_run;

  assign idx_end  = (idx_q == idx_last);
  assign out_free = !m_valid_q || m_axis_tready;
  assign k_run    = (k_q != '0) && (r_q != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:     if (in_acc && s_axis_tlast) state_d = ST_SP;
      ST_SP:       state_d = (uni == '0) ? ST_A_RD : ST_SP_WAIT;
      ST_SP_WAIT:  if (div_rsp.done) state_d = ST_A_RD;
      ST_A_RD:     state_d = ST_A_ACC;
      ST_A_ACC: begin
        if (rd_s != '0)   state_d = ST_A_WAIT;
        else if (idx_end) state_d = ST_B_CHK;
        else              state_d = ST_A_RD;
      end
      ST_A_WAIT:   if (div_rsp.done) state_d = idx_end ? ST_B_CHK : ST_A_RD;
      ST_B_CHK:    state_d = (ta_q == '0 || tb_q == '0) ? ST_DU : ST_B_RD;
      ST_B_RD:     state_d = ST_B_LAT;
      ST_B_LAT:    state_d = ST_B_DIVA;
      ST_B_DIVA:   if (div_rsp.done) state_d = ST_B_DIVB;
      ST_B_DIVB:   if (div_rsp.done) state_d = idx_end ? ST_DU : ST_B_RD;
      ST_DU:       state_d = ST_DU_WAIT;
      ST_DU_WAIT:  if (div_rsp.done) state_d = ST_SQ;
      ST_SQ:       state_d = ST_X;
      ST_X:        state_d = ST_X_WAIT;
      ST_X_WAIT:   if (div_rsp.done) state_d = ST_TAY_MUL;
      ST_TAY_MUL:  state_d = ST_TAY_DIV;
      ST_TAY_DIV:  state_d = ST_TAY_WAIT;
      ST_TAY_WAIT: if (div_rsp.done) state_d = (nstep_q == TAYLOR_N) ? ST_CLAMP : ST_TAY_MUL;
      ST_CLAMP:    state_d = ST_KLOOP;
      ST_KLOOP:    if (!k_run) state_d = ST_ROUND;
      ST_ROUND:    state_d = ST_FIN;
      ST_FIN:      if (out_free) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // sequencer outputs: ready, memory read address, divider requests
  always_comb begin
    s_axis_tready    = (state_q == ST_LOAD);
    rd_addr          = idx_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      ST_SP: begin
        div_req.start    = (uni != '0);
        div_req.dividend = DIV_N_W'({common_q, {FRAC_W{1'b0}}});
        div_req.divisor  = DIV_D_W'(uni);
      end
      ST_A_ACC: begin
        div_req.start    = (rd_s != '0);
        div_req.dividend = DIV_N_W'({rd_d, {FRAC_W{1'b0}}});
        div_req.divisor  = DIV_D_W'(rd_s);
      end
      ST_B_LAT: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'({rd_a, {FRAC_W{1'b0}}});
        div_req.divisor  = ta_q;
      end
      ST_B_DIVA: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_N_W'({b_q, {FRAC_W{1'b0}}});
        div_req.divisor  = tb_q;
      end
      ST_DU: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(dsum_q);
        div_req.divisor  = DIV_D_W'(n_eff);
      end
      ST_X: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'({sq_q, {FRAC_W{1'b0}}});
        div_req.divisor  = DIV_D_W'(ls_eff);
      end
      ST_TAY_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(prod_q);
        div_req.divisor  = DIV_D_W'(nstep_q);
      end
      default: ;
    endcase
  end

  // ---------------- result ----------------
  logic [Q_W-1:0]   nrm, qd;
  logic [Q_W-1:0]   mix_nh, mix_nt, mix_gh, mix_gt, mix_qh, mix_qt;
  logic [Q_W+1:0]   sp3;
  logic [190:0]     res_word;
  logic [Q_W+1:0]   r_rnd;
  logic [2*Q_W-1:0] du_sq;
  logic [Q32_W+31:0] tay_prod, ek_prod;
  logic [Q32_W-1:0] q_lo;

  assign nrm    = ONE_Q - du_q;
  assign qd     = ONE_Q - sq_q;
  assign sp3    = {2'b0, sp_q} + {1'b0, sp_q, 1'b0};
  assign mix_nh = Q_W'(({1'b0, sp_q} + {1'b0, nrm}) >> 1);
  assign mix_nt = Q_W'((sp3 + (Q_W+2)'(nrm)) >> 2);
  assign mix_gh = Q_W'(({1'b0, sp_q} + {1'b0, gs_q}) >> 1);
  assign mix_gt = Q_W'((sp3 + (Q_W+2)'(gs_q)) >> 2);
  assign mix_qh = Q_W'(({1'b0, sp_q} + {1'b0, qd}) >> 1);
  assign mix_qt = Q_W'((sp3 + (Q_W+2)'(qd)) >> 2);
  assign res_word = {4'b0, mix_qt, mix_qh, mix_gt, mix_gh, mix_nt, mix_nh,
                     qd, gs_q, nrm, vd_q, sp_q};

  assign du_sq    = du_q * du_q;
  assign tay_prod = term_q * fi_q;
  assign ek_prod  = r_q * EINV_Q32;
  assign r_rnd    = (Q_W+2)'((r_q + (Q32_W'(1) << (31 - FRAC_W))) >> (32 - FRAC_W));
  assign q_lo     = div_rsp.quotient[Q32_W-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      m_valid_q <= 1'b0;
      common_q  <= '0;
      sf_q      <= '0;
      sb_q      <= '0;
      vld_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        m_valid_q <= 1'b1;
        vld_q     <= '0;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (in_acc) begin
        if (req_e'(s_axis_tuser[0]) == REQ_PIXEL) begin
          if (sf_q != CNT_MAX) sf_q <= sf_q + CNT_W'(in_a);
          if (sb_q != CNT_MAX) sb_q <= sb_q + CNT_W'(in_b);
          if (common_q != CNT_MAX) common_q <= common_q + CNT_W'(in_a & in_b);
        end else begin
          vld_q[in_idx] <= 1'b1;
        end
      end
    end
  end

  // memory port
  always_ff @(posedge clk_i) begin
    if (in_acc && req_e'(s_axis_tuser[0]) == REQ_COUNT) mem[in_idx] <= {in_cb, in_ca};
    rd_q     <= mem[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
  end

  // compute datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        idx_q    <= '0;
        status_q <= 2'b00;
        sp_q     <= '0;
        ta_q     <= '0;
        tb_q     <= '0;
        dsum_q   <= '0;
        vsum_q   <= '0;
      end
      ST_SP: if (uni == '0) status_q[0] <= 1'b1;
      ST_SP_WAIT: if (div_rsp.done)
        sp_q <= (div_rsp.quotient > DIV_N_W'(ONE_Q)) ? ONE_Q : div_rsp.quotient[Q_W-1:0];
      ST_A_ACC: begin
        ta_q <= ta_q + TOT_W'(rd_a);
        tb_q <= tb_q + TOT_W'(rd_b);
        if (rd_s == '0) idx_q <= idx_q + 1'b1;
      end
      ST_A_WAIT: if (div_rsp.done) begin
        dsum_q <= dsum_q + DSUM_W'(div_rsp.quotient[Q_W-1:0]);
        idx_q  <= idx_q + 1'b1;
      end
      ST_B_CHK: begin
        idx_q <= '0;
        vd_q  <= '0;
        if (ta_q == '0 || tb_q == '0) status_q[1] <= 1'b1;
      end
      ST_B_LAT: b_q <= rd_b;
      ST_B_DIVA: if (div_rsp.done) pa_q <= div_rsp.quotient[Q_W-1:0];
      ST_B_DIVB: if (div_rsp.done) begin
        vsum_q <= vsum_q + DSUM_W'((pa_q < div_rsp.quotient[Q_W-1:0]) ?
                                   pa_q : div_rsp.quotient[Q_W-1:0]);
        idx_q  <= idx_q + 1'b1;
      end
      ST_DU: if (status_q[1] == 1'b0)
        vd_q <= (vsum_q > DSUM_W'(ONE_Q)) ? ONE_Q : vsum_q[Q_W-1:0];
      ST_DU_WAIT: if (div_rsp.done)
        du_q <= (div_rsp.quotient > DIV_N_W'(ONE_Q)) ? ONE_Q : div_rsp.quotient[Q_W-1:0];
      ST_SQ: sq_q <= du_sq[FRAC_W +: Q_W];
      ST_X_WAIT: if (div_rsp.done) begin
        k_q     <= div_rsp.quotient[FRAC_W +: Q_W];
        fi_q    <= {div_rsp.quotient[FRAC_W-1:0], {(32-FRAC_W){1'b0}}};
        term_q  <= Q32_ONE;
        sum_q   <= (Q32_W+2)'(Q32_ONE);
        nstep_q <= 4'd1;
      end
      ST_TAY_MUL: prod_q <= tay_prod[32 +: Q32_W];
      ST_TAY_WAIT: if (div_rsp.done) begin
        term_q  <= q_lo;
        sum_q   <= nstep_q[0] ? sum_q - $signed({2'b0, q_lo}) : sum_q + $signed({2'b0, q_lo});
        nstep_q <= nstep_q + 1'b1;
      end
      ST_CLAMP: begin
        if (sum_q < 0)                                r_q <= '0;
        else if (sum_q > $signed({2'b0, Q32_ONE}))    r_q <= Q32_ONE;
        else                                          r_q <= sum_q[Q32_W-1:0];
      end
      ST_KLOOP: if (k_run) begin
        r_q <= ek_prod[32 +: Q32_W];
        k_q <= k_q - 1'b1;
      end
      ST_ROUND: gs_q <= (r_rnd > (Q_W+2)'(ONE_Q)) ? ONE_Q : r_rnd[Q_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      m_axis_tdata <= {1'b0, res_word};
      m_axis_tuser <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;

endmodule

`default_nettype wire

### design/bmsi_div.sv
// Restoring divider, one quotient bit per cycle; done pulses once the last
// quotient bit is in. Depends on bmsi_pkg.
`default_nettype none

module bmsi_div import bmsi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q, den_q;
  logic [DIV_D_W:0]     trial, diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### design/bmsi_checker.sv
// Port-level checker for the burn map similarity block, bound to the top.
// Depends on bmsi_pkg.
`default_nettype none

module bmsi_checker import bmsi_pkg::*; (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         cfg_valid_i,
  input wire logic         cfg_ready_o,
  input wire logic [0:0]   cfg_addr_i,
  input wire logic [15:0]  cfg_data_i,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [47:0]  s_axis_tdata,
  input wire logic [0:0]   s_axis_tuser,
  input wire logic         s_axis_tlast,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // compute starts after the last request, input closes
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open during compute");

  // empty union reports zero overlap
  a_empty_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[16:0] == '0)
    else $error("spatial overlap nonzero with empty union");

  // zero veg total reports zero distribution overlap
  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[33:17] == '0)
    else $error("veg overlap nonzero with zero total");

endmodule

bind burn_map_similarity_indices bmsi_checker u_bmsi_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Testbench for burn_map_similarity_indices: drives pixel and veg count requests,
// predicts the eleven Q1.16 indices in a scoreboard class. Depends on bmsi_pkg.
`default_nettype none

module tb_top;
  import bmsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one request as the stream carries it
  typedef struct {
    req_e        kind;
    logic        burned_a;
    logic        burned_b;
    logic [3:0]  veg_index;
    logic [20:0] count_a;
    logic [20:0] count_b;
    logic        last;
  } map_req_t;

  typedef struct {
    logic [191:0] data;
    logic [1:0]   status;
  } index_set_t;

  // predictor and checker of the similarity indices
  class similarity_scoreboard;
    longint unsigned len_scale, types_used;
    longint unsigned common_px, size_a, size_b;
    longint unsigned veg_a[16], veg_b[16];
    index_set_t      pending[$];
    int              mismatches;

    function void clear_all();
      len_scale = 13107; types_used = 16;
      common_px = 0; size_a = 0; size_b = 0;
      foreach (veg_a[i]) begin
        veg_a[i] = 0; veg_b[i] = 0;
      end
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] val);
      if (idx == CFG_LENGTH_SCALE) len_scale = val;
      else types_used = val & 16'h1f;
    endfunction

    function longint unsigned sat_add(longint unsigned v, longint unsigned d);
      return (v + d > 64'h1fffff) ? 64'h1fffff : v + d;
    endfunction

    function longint unsigned exp_minus(longint unsigned xq);
      longint unsigned k, fi, term, r;
      longint          acc;
      k = xq >> 16;
      fi = (xq & 64'hffff) << 16;
      term = 64'h1_0000_0000;
      acc = 64'sh1_0000_0000;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * fi) >> 32) / n;
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      r = acc < 0 ? 0 : longint'(acc);
      if (r > 64'h1_0000_0000) r = 64'h1_0000_0000;
      while (k > 0 && r > 0) begin
        r = (r * 64'd1580030169) >> 32;
        k--;
      end
      r = (r + (64'd1 << 15)) >> 16;
      return r > 65536 ? 65536 : r;
    endfunction

    function void note_request(map_req_t rq);
      longint unsigned sp, vd, nrm, gs, qd, uni, ta, tb, dsum, du, sq, xq, ls, n;
      longint unsigned o[11], pa, pb, s, d;
      index_set_t      exp_set;
      logic [1:0]      st;
      if (rq.kind == REQ_PIXEL) begin
        size_a = sat_add(size_a, rq.burned_a);
        size_b = sat_add(size_b, rq.burned_b);
        common_px = sat_add(common_px, rq.burned_a & rq.burned_b);
      end else begin
        veg_a[rq.veg_index] = rq.count_a;
        veg_b[rq.veg_index] = rq.count_b;
      end
      if (!rq.last) return;
      st = 0; ta = 0; tb = 0; dsum = 0; vd = 0;
      n = types_used;
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      uni = size_a + size_b - common_px;
      if (uni == 0) begin
        sp = 0; st[0] = 1;
      end else sp = (common_px << 16) / uni;
      if (sp > 65536) sp = 65536;
      for (int v = 0; v < n; v++) begin
        ta += veg_a[v]; tb += veg_b[v];
      end
      if (ta == 0 || tb == 0) st[1] = 1;
      else begin
        for (int v = 0; v < n; v++) begin
          pa = (veg_a[v] << 16) / ta;
          pb = (veg_b[v] << 16) / tb;
          vd += pa < pb ? pa : pb;
        end
        if (vd > 65536) vd = 65536;
      end
      for (int v = 0; v < n; v++) begin
        s = veg_a[v] + veg_b[v];
        if (s > 0) begin
          d = veg_a[v] > veg_b[v] ? veg_a[v] - veg_b[v] : veg_b[v] - veg_a[v];
          dsum += (d << 16) / s;
        end
      end
      du = dsum / n;
      if (du > 65536) du = 65536;
      nrm = 65536 - du;
      sq = (du * du) >> 16;
      qd = 65536 - sq;
      ls = len_scale == 0 ? 1 : len_scale;
      xq = (sq << 16) / ls;
      gs = exp_minus(xq);
      o[0] = sp; o[1] = vd; o[2] = nrm; o[3] = gs; o[4] = qd;
      o[5] = (sp + nrm) >> 1; o[6] = (3 * sp + nrm) >> 2;
      o[7] = (sp + gs) >> 1;  o[8] = (3 * sp + gs) >> 2;
      o[9] = (sp + qd) >> 1;  o[10] = (3 * sp + qd) >> 2;
      exp_set.data = '0;
      for (int j = 0; j < 11; j++) exp_set.data[j*17 +: 17] = o[j][16:0];
      exp_set.status = st;
      pending.push_back(exp_set);
      foreach (veg_a[i]) begin
        veg_a[i] = 0; veg_b[i] = 0;
      end
    endfunction

    function void check_result(logic [191:0] data, logic [1:0] status);
      index_set_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h status %0d", data, status);
        return;
      end
      e = pending.pop_front();
      for (int j = 0; j < 11; j++)
        if (data[j*17 +: 17] !== e.data[j*17 +: 17]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("index %0d: expected %0d got %0d", j, e.data[j*17 +: 17],
                     data[j*17 +: 17]);
        end
      if (data[191:187] !== 5'd0 || status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status: expected %0d got %0d (pad %b)", e.status, status,
                   data[191:187]);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [0:0]   cfg_addr_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  burn_map_similarity_indices dut (.*);

  similarity_scoreboard board;
  int  idle_cycles;           // cycles without any handshake, for the watchdog
  bit  hold_sink;             // asks the result side for one long hold-off
  localparam int HOLD_CYCLES = 8000;    // spans two computes, so results back up
  localparam int WATCHDOG = 200000;     // idle_cycles limit before the watchdog fails the test

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, one long hold-off counted here
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_sink = 0;
      end else begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(negedge clk_i);
        end
        m_axis_tready <= 1;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
        board.check_result(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("burn_map_similarity_indices test failed");
      $finish;
    end
  end

  task automatic send_req(map_req_t rq, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= rq.kind;
    s_axis_tlast <= rq.last;
    s_axis_tdata <= {rq.count_b, rq.count_a, rq.veg_index, rq.burned_b, rq.burned_a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(rq);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // waits for all results, then lets the compute engine settle
  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
  endtask

  function automatic map_req_t pixel(bit a, bit b, bit lst);
    map_req_t rq;
    rq = '{REQ_PIXEL, a, b, 4'($urandom), 21'($urandom), 21'($urandom), lst};
    return rq;
  endfunction

  function automatic map_req_t veg(logic [3:0] i, logic [20:0] ca, logic [20:0] cb,
                                   bit lst);
    map_req_t rq;
    rq = '{REQ_COUNT, 1'($urandom), 1'($urandom), i, ca, cb, lst};
    return rq;
  endfunction

  // random count: often small, otherwise zero, half scale, full scale or random
  function automatic logic [20:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 21'h100000;
      2: return 21'h1fffff;
      3: return 21'($urandom);
      default: return 21'($urandom_range(0, 50));
    endcase
  endfunction

  initial begin
    int        sent, nveg, npix;
    logic [15:0] ls_pick;
    board = new();
    board.clear_all();
    idle_cycles = 0;
    hold_sink = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty maps, then extremes with defaults
    send_req(pixel(0, 0, 1));                 // empty union and zero veg totals
    send_req(pixel(1, 1, 0));
    send_req(pixel(1, 0, 0));
    send_req(pixel(0, 1, 0));
    send_req(veg(0, 21'h1fffff, 0, 0));
    send_req(veg(15, 21'h1fffff, 21'h1fffff, 0));
    send_req(veg(7, 0, 21'h100000, 1));
    send_req(veg(3, 5, 5, 0));
    send_req(veg(4, 21'h155555, 21'h0aaaaa, 1));
    send_req(veg(2, 9, 0, 1));                // one map empty in veg
    drain();
    write_cfg(CFG_LENGTH_SCALE, 16'd1);
    write_cfg(CFG_VEG_TYPES, 16'd1);
    send_req(veg(0, 3, 1, 0));
    send_req(veg(1, 1, 3, 1));                // type outside n ignored
    send_req(veg(0, 1, 0, 1));
    drain();
    write_cfg(CFG_LENGTH_SCALE, 16'd0);       // zero scale acts as one
    write_cfg(CFG_VEG_TYPES, 16'd0);          // clamped up to one
    send_req(veg(0, 1, 2, 1));
    drain();
    write_cfg(CFG_LENGTH_SCALE, 16'hffff);
    write_cfg(CFG_VEG_TYPES, 16'h001f);       // clamped down to sixteen
    send_req(veg(9, 100, 1, 0));
    send_req(veg(12, 2, 80, 1));
    drain();

    // random runs: each a set of pixels and veg pairs ended by last
    sent = 0;
    for (int run = 0; sent < 1200; run++) begin
      if (run % 6 == 5) begin
        drain();                               // sender waits for every result
        case ($urandom_range(0, 3))
          0: ls_pick = 16'd1;
          1: ls_pick = 16'hffff;
          default: ls_pick = 16'($urandom);
        endcase
        write_cfg(CFG_LENGTH_SCALE, ls_pick);
        write_cfg(CFG_VEG_TYPES, 16'($urandom_range(0, 31)));
      end
      if (run == 3) hold_sink = 1;             // block fills up while results wait
      nveg = $urandom_range(0, 6);
      npix = $urandom_range(0, 20);
      for (int i = 0; i < npix + nveg; i++) begin
        if ($urandom_range(0, npix + nveg - 1) < nveg)
          send_req(veg(4'($urandom), rand_count(), rand_count(), 0), hold_sink);
        else
          send_req(pixel(1'($urandom), 1'($urandom), 0), $urandom_range(0, 3) == 0);
        sent++;
      end
      if ($urandom_range(0, 1))
        send_req(veg(4'($urandom), rand_count(), rand_count(), 1));
      else
        send_req(pixel(1'($urandom), 1'($urandom), 1));
      sent++;
    end
    idle_input();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (board.mismatches == 0) $display("burn_map_similarity_indices test passed");
    else $display("burn_map_similarity_indices test failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/bmsi_pkg.sv
design/bmsi_div.sv
design/burn_map_similarity_indices.sv
design/bmsi_checker.sv
tb/tb_top.sv
